// File: rtl/core/mbt_pkg.sv
// ----------------------------------------------------------------------------
// mbt_pkg
// Shared types, codes and helpers of the multibit trie route lookup engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbt_pkg;

  localparam int ADDR_W    = 32;
  localparam int IDX_W     = 17;
  localparam int LINK_W    = 12;
  localparam int ACT_W     = 2;
  localparam int PORT_W    = 16;
  localparam int NB_W      = 12;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int ENTRY_W   = 2 + LINK_W;
  localparam int HOP_W     = ACT_W + ADDR_W + PORT_W + NB_W;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;
  localparam int IN_DW     = 128;
  localparam int OUT_DW    = 64;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_LOOKUP  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TRIE_WR = 2'd1;
  localparam logic [REQ_W-1:0] REQ_HOP_WR  = 2'd2;

  // actions and result status
  localparam logic [ACT_W-1:0]    ACT_FWD   = 2'd0;
  localparam logic [ACT_W-1:0]    ACT_DROP  = 2'd1;
  localparam logic [ACT_W-1:0]    ACT_RECV  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FWD    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROP   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RECV   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISS   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DONE   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_PRESENT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_ACTION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_GATEWAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_PORT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_NEIGHBOR = 3'd4;

  typedef struct packed {
    logic              valid;
    logic              last;
    logic [LINK_W-1:0] link;
  } trie_entry_t;

  typedef struct packed {
    logic [NB_W-1:0]   neighbor;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] gateway;
    logic [ACT_W-1:0]  action;
  } hop_rec_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   gateway;
    logic [PORT_W-1:0]   port;
    logic [NB_W-1:0]     neighbor;
  } result_t;

  function automatic result_t make_result(input logic [ACT_W-1:0] act,
                                          input logic [ADDR_W-1:0] gw,
                                          input logic [PORT_W-1:0] port,
                                          input logic [NB_W-1:0] nb);
    result_t r;
    r = '0;
    case (act)
      ACT_FWD: begin
        r.status   = ST_FWD;
        r.gateway  = gw;
        r.port     = port;
        r.neighbor = nb;
      end
      ACT_RECV: r.status = ST_RECV;
      default:  r.status = ST_DROP;
    endcase
    return r;
  endfunction

  function automatic result_t status_result(input logic [STATUS_W-1:0] st);
    result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mbt_ram.sv
// ----------------------------------------------------------------------------
// mbt_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbt_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 131072,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/multibit_trie_route_lookup.sv
// ----------------------------------------------------------------------------
// multibit_trie_route_lookup
// IPv4 longest-prefix-match engine walking a multibit trie, plus table writes.
// ----------------------------------------------------------------------------
// Input words on in_* carry a request kind in in_tuser: lookup, trie entry
// write or next-hop record write. Every word yields exactly one output word
// on out_* with the status in out_tuser and forwarding fields in out_tdata.
// Writes answer in the cycle after acceptance. A lookup issues one trie
// memory read per level and, on an end entry, one next-hop read, all through
// the single read port of each memory; the result is registered in the
// output register once the walk ends.
// One word is in flight at a time: in_tready is high only while the engine
// is idle and the output register is empty, so a stalled receiver holds the
// result in out_tdata and stops further input.
// After reset the trie memory is swept to invalid, one entry per cycle, over
// all FIRST_SIZE + SUBTABLES * SUB_SIZE entries (131072 with default settings);
// no input word is taken during the sweep, configuration writes are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multibit_trie_route_lookup #(
  parameter int FIRST_STRIDE = 16,
  parameter int SUB_STRIDE   = 4,
  parameter int LEVELS       = 5,
  parameter int SUBTABLES    = 4096,
  parameter int NEXT_HOPS    = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // dest_addr, entry_index, entry_valid, entry_end, entry_link, hop_action,
  // hop_gateway, hop_port, hop_neighbor, zero fill
  input  wire logic [mbt_pkg::IN_DW-1:0]           in_tdata,
  // req_type
  input  wire logic [mbt_pkg::REQ_W-1:0]           in_tuser,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // gateway, out_port, neighbor_id, zero fill
  output logic      [mbt_pkg::OUT_DW-1:0]          out_tdata,
  // status
  output logic      [mbt_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_we,
  input  wire logic [mbt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mbt_pkg::CFG_DW-1:0]          cfg_wdata
);

  localparam int FIRST_SIZE = 1 << FIRST_STRIDE;
  localparam int SUB_SIZE   = 1 << SUB_STRIDE;
  localparam int TRIE_DEPTH = FIRST_SIZE + SUBTABLES * SUB_SIZE;
  localparam int TA_W       = $clog2(TRIE_DEPTH);
  localparam int HA_W       = $clog2(NEXT_HOPS);
  localparam int LV_W       = $clog2(LEVELS);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_TRIE,
    S_HOP
  } state_t;

  // input word fields
  logic [mbt_pkg::ADDR_W-1:0] in_dest;
  logic [mbt_pkg::IDX_W-1:0]  in_index;
  mbt_pkg::trie_entry_t       in_entry;
  mbt_pkg::hop_rec_t          in_hop;
  logic                       in_accept;

  assign in_dest        = in_tdata[31:0];
  assign in_index       = in_tdata[48:32];
  assign in_entry.valid = in_tdata[49];
  assign in_entry.last  = in_tdata[50];
  assign in_entry.link  = in_tdata[62:51];
  assign in_hop.action  = in_tdata[64:63];
  assign in_hop.gateway = in_tdata[96:65];
  assign in_hop.port    = in_tdata[112:97];
  assign in_hop.neighbor = in_tdata[124:113];
  assign in_accept      = in_tvalid && in_tready;

  // default route registers
  logic                         def_present_r;
  logic [mbt_pkg::ACT_W-1:0]    def_action_r;
  logic [mbt_pkg::ADDR_W-1:0]   def_gateway_r;
  logic [mbt_pkg::PORT_W-1:0]   def_port_r;
  logic [mbt_pkg::NB_W-1:0]     def_neighbor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_present_r  <= 1'b0;
      def_action_r   <= '0;
      def_gateway_r  <= '0;
      def_port_r     <= '0;
      def_neighbor_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbt_pkg::CFG_DEF_PRESENT:  def_present_r  <= cfg_wdata[0];
        mbt_pkg::CFG_DEF_ACTION:   def_action_r   <= cfg_wdata[mbt_pkg::ACT_W-1:0];
        mbt_pkg::CFG_DEF_GATEWAY:  def_gateway_r  <= cfg_wdata[mbt_pkg::ADDR_W-1:0];
        mbt_pkg::CFG_DEF_PORT:     def_port_r     <= cfg_wdata[mbt_pkg::PORT_W-1:0];
        mbt_pkg::CFG_DEF_NEIGHBOR: def_neighbor_r <= cfg_wdata[mbt_pkg::NB_W-1:0];
        default: ;
      endcase
    end
  end

  // memories
  logic                         trie_we;
  logic [TA_W-1:0]              trie_waddr;
  logic [mbt_pkg::ENTRY_W-1:0]  trie_wdata;
  logic [TA_W-1:0]              trie_raddr;
  logic [mbt_pkg::ENTRY_W-1:0]  trie_rdata;
  logic                         hop_we;
  logic [HA_W-1:0]              hop_waddr;
  logic [mbt_pkg::HOP_W-1:0]    hop_wdata;
  logic [HA_W-1:0]              hop_raddr;
  logic [mbt_pkg::HOP_W-1:0]    hop_rdata;

  mbt_ram #(
    .WIDTH (mbt_pkg::ENTRY_W),
    .DEPTH (TRIE_DEPTH)
  ) u_trie_ram (
    .clk   (clk),
    .we    (trie_we),
    .waddr (trie_waddr),
    .wdata (trie_wdata),
    .raddr (trie_raddr),
    .rdata (trie_rdata)
  );

  mbt_ram #(
    .WIDTH (mbt_pkg::HOP_W),
    .DEPTH (NEXT_HOPS)
  ) u_hop_ram (
    .clk   (clk),
    .we    (hop_we),
    .waddr (hop_waddr),
    .wdata (hop_wdata),
    .raddr (hop_raddr),
    .rdata (hop_rdata)
  );

  mbt_pkg::trie_entry_t rd_entry;
  mbt_pkg::hop_rec_t    rd_hop;
  mbt_pkg::result_t     def_result;

  assign rd_entry = mbt_pkg::trie_entry_t'(trie_rdata);
  assign rd_hop   = mbt_pkg::hop_rec_t'(hop_rdata);
  assign def_result = def_present_r ?
      mbt_pkg::make_result(def_action_r, def_gateway_r, def_port_r, def_neighbor_r) :
      mbt_pkg::status_result(mbt_pkg::ST_MISS);

  // sequencer
  state_t                     state_r, state_nxt;
  logic [TA_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [LV_W-1:0]            lvl_r, lvl_nxt;
  logic [mbt_pkg::ADDR_W-1:0] addr_sh_r, addr_sh_nxt;
  logic                       out_valid_r, out_valid_nxt;
  mbt_pkg::result_t           res_r, res_nxt;
  logic [TA_W-1:0]            first_addr;
  logic [TA_W-1:0]            next_addr;

  assign first_addr = TA_W'(in_dest[mbt_pkg::ADDR_W-1 -: FIRST_STRIDE]);
  assign next_addr  = TA_W'(FIRST_SIZE) +
                      TA_W'({rd_entry.link, addr_sh_r[mbt_pkg::ADDR_W-1 -: SUB_STRIDE]});

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    lvl_nxt       = lvl_r;
    addr_sh_nxt   = addr_sh_r;
    out_valid_nxt = out_valid_r && !out_tready;
    res_nxt       = res_r;
    trie_we       = 1'b0;
    trie_waddr    = clr_cnt_r;
    trie_wdata    = '0;
    trie_raddr    = next_addr;
    hop_we        = 1'b0;
    hop_waddr     = HA_W'(in_index);
    hop_wdata     = in_hop;
    hop_raddr     = HA_W'(rd_entry.link);
    unique case (state_r)
      S_CLEAR: begin
        trie_we = 1'b1;
        if (clr_cnt_r == TA_W'(TRIE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        trie_raddr = first_addr;
        if (in_accept) begin
          case (in_tuser)
            mbt_pkg::REQ_LOOKUP: begin
              state_nxt   = S_TRIE;
              lvl_nxt     = '0;
              addr_sh_nxt = in_dest << FIRST_STRIDE;
            end
            mbt_pkg::REQ_TRIE_WR: begin
              trie_we       = 32'(in_index) < 32'(TRIE_DEPTH);
              trie_waddr    = TA_W'(in_index);
              trie_wdata    = in_entry;
              out_valid_nxt = 1'b1;
              res_nxt       = mbt_pkg::status_result(mbt_pkg::ST_DONE);
            end
            mbt_pkg::REQ_HOP_WR: begin
              hop_we        = 32'(in_index) < 32'(NEXT_HOPS);
              out_valid_nxt = 1'b1;
              res_nxt       = mbt_pkg::status_result(mbt_pkg::ST_DONE);
            end
            default: begin
              out_valid_nxt = 1'b1;
              res_nxt       = mbt_pkg::status_result(mbt_pkg::ST_MISS);
            end
          endcase
        end
      end
      S_TRIE: begin
        if (!rd_entry.valid) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = def_result;
        end else if (rd_entry.last) begin
          if (32'(rd_entry.link) < 32'(NEXT_HOPS)) begin
            state_nxt = S_HOP;
          end else begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            res_nxt       = def_result;
          end
        end else if (32'(rd_entry.link) >= 32'(SUBTABLES)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = def_result;
        end else if (lvl_r == LV_W'(LEVELS - 1)) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          res_nxt       = mbt_pkg::status_result(mbt_pkg::ST_MISS);
        end else begin
          lvl_nxt     = lvl_r + 1'b1;
          addr_sh_nxt = addr_sh_r << SUB_STRIDE;
        end
      end
      S_HOP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        res_nxt       = mbt_pkg::make_result(rd_hop.action, rd_hop.gateway,
                                             rd_hop.port, rd_hop.neighbor);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_sh_r <= addr_sh_nxt;
    res_r     <= res_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.status;
  assign out_tdata  = mbt_pkg::OUT_DW'({res_r.neighbor, res_r.port, res_r.gateway});

  // checks
  a_lookup_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == mbt_pkg::REQ_LOOKUP) |=> !out_tvalid)
    else $error("lookup answered in the cycle after acceptance");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_tuser == mbt_pkg::REQ_TRIE_WR || in_tuser == mbt_pkg::REQ_HOP_WR))
    |=> (out_tvalid && out_tuser == mbt_pkg::ST_DONE))
    else $error("table write did not answer write done");

  a_hop_answers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOP) |=> (out_tvalid && out_tuser != mbt_pkg::ST_MISS &&
                            out_tuser != mbt_pkg::ST_DONE))
    else $error("next-hop read did not produce a route result");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != mbt_pkg::ST_FWD) |-> (out_tdata == '0))
    else $error("non-forward result carries nonzero fields");

  a_no_walk_while_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TRIE || state_r == S_HOP) |-> !out_tvalid)
    else $error("walk in progress while a result is still held");

endmodule

`default_nettype wire
